FILE: rtl/mtg_pkg.sv
// Shared types and constants for the motion threshold gate.
package mtg_pkg;

  // Event kinds; codes above wake are handled as other events
  localparam logic [2:0] OP_MOTION = 3'd0;
  localparam logic [2:0] OP_BUTTON = 3'd1;
  localparam logic [2:0] OP_SCROLL = 3'd2;
  localparam logic [2:0] OP_OTHER  = 3'd3;
  localparam logic [2:0] OP_WAKE   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_WAKE_SUP  = 3'd2;
  localparam logic [2:0] REG_BLK_BTN   = 3'd3;
  localparam logic [2:0] REG_BLK_SCR   = 3'd4;

  // Restoring divider: one quotient bit per step over a 33-bit dividend
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_step;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic decay_en;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mtg_ctrl.sv
// Sequencer for the motion threshold gate: accept, multiply, divide (only when decay applies), update.
module mtg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mtg_pkg::sts_t sts,
  output mtg_pkg::cmd_t cmd
);
  import mtg_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.mul      = 1'b0;
    cmd.div_step = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.decay_en ? ST_DIV : ST_UPD;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = ST_UPD;
      end
      ST_UPD: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule

FILE: rtl/mtg_dp.sv
// Datapath for the motion threshold gate: registers, decay divider, gate logic.
module mtg_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         opcode,
  input  logic               end_of_frame,
  input  logic signed [15:0] event_value,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pass_event,
  output logic               is_blocked,
  input  mtg_pkg::cmd_t      cmd,
  output mtg_pkg::sts_t      sts
);
  import mtg_pkg::*;

  // Configuration
  logic [15:0] thr, win, wsup;
  logic        blk_btn, blk_scr;

  // Latched transaction
  logic [2:0]  op_q;
  logic        sync_q;
  logic [15:0] val_q;
  logic [31:0] now_q;

  // Gate state
  logic [16:0] credit;
  logic        blocked, skip;
  logic [31:0] last;
  logic [32:0] rec_end;
  logic        armed;

  // Divider
  logic [32:0]      quo;
  logic [15:0]      rem;
  logic [CNT_W-1:0] cnt;

  // Next state from the update logic
  logic [16:0] credit_next;
  logic        blocked_next, skip_next, armed_next, pass_next;
  logic [31:0] last_next;
  logic [32:0] rec_end_next;

  logic [31:0] dt;
  logic [16:0] lim, dtc;
  logic [32:0] prod;
  logic [16:0] trial, diff;
  logic        ge;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= 16'd50;
      win     <= 16'd100;
      wsup    <= 16'd0;
      blk_btn <= 1'b0;
      blk_scr <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr     <= cfg_data;
        REG_WINDOW:    win     <= cfg_data;
        REG_WAKE_SUP:  wsup    <= cfg_data;
        REG_BLK_BTN:   blk_btn <= cfg_data[0];
        REG_BLK_SCR:   blk_scr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= opcode;
      sync_q <= end_of_frame;
      val_q  <= event_value;
      now_q  <= now_ms;
    end
  end

  // Elapsed time, clamped to twice the window, times threshold
  assign sts.decay_en = (now_q > last) && (win != 16'd0) && (op_q != OP_WAKE);
  assign dt   = now_q - last;
  assign lim  = {win, 1'b0};
  assign dtc  = (dt > {15'd0, lim}) ? lim : dt[16:0];
  assign prod = {16'd0, dtc} * {17'd0, thr};

  // Restoring division step
  assign trial = {rem, quo[32]};
  assign ge    = (trial >= {1'b0, win});
  assign diff  = trial - {1'b0, win};
  assign sts.div_done = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo <= prod;
      rem <= 16'd0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[31:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
      cnt <= cnt + 1'b1;
    end
  end

  // Gate update for one event; quo holds the decay amount when decay_en
  always_comb begin
    logic [16:0] cr;
    logic [15:0] mag;
    logic [16:0] cap;
    logic [17:0] sum;
    cr           = credit;
    blocked_next = blocked;
    skip_next    = skip;
    armed_next   = armed;
    rec_end_next = rec_end;
    last_next    = last;
    pass_next    = 1'b0;
    mag          = val_q[15] ? (16'd0 - val_q) : val_q;
    cap          = {thr, 1'b0};
    sum          = 18'd0;
    if (op_q == OP_WAKE) begin
      if (wsup != 16'd0) begin
        rec_end_next = {1'b0, now_q} + {17'd0, wsup};
        armed_next   = 1'b1;
        cr           = 17'd0;
        blocked_next = 1'b1;
        skip_next    = 1'b0;
      end
    end else begin
      if (sts.decay_en) begin
        cr = (quo >= {16'd0, credit}) ? 17'd0 : (credit - quo[16:0]);
      end
      last_next = now_q;
      if (armed && ({1'b0, now_q} < rec_end) && !sync_q && (op_q == OP_MOTION)) begin
        // motion inside the wake window
        cr           = 17'd0;
        blocked_next = 1'b1;
        skip_next    = 1'b0;
      end else begin
        if ((cr == 17'd0) && !blocked_next) begin
          blocked_next = 1'b1;
          skip_next    = 1'b0;
        end
        if (sync_q) begin
          pass_next = !(blocked_next || skip_next);
          skip_next = 1'b0;
        end else if (op_q != OP_MOTION) begin
          // other codes above wake fall through as other events
          if (!blocked_next)                         pass_next = 1'b1;
          else if ((op_q == OP_BUTTON) && blk_btn)   pass_next = 1'b0;
          else if ((op_q == OP_SCROLL) && blk_scr)   pass_next = 1'b0;
          else                                       pass_next = 1'b1;
        end else begin
          sum = {1'b0, cr} + {2'd0, mag};
          cr  = (sum > {1'b0, cap}) ? cap : sum[16:0];
          if (!blocked_next && !skip_next) begin
            pass_next = 1'b1;
          end else if (cr >= {1'b0, thr}) begin
            blocked_next = 1'b0;
            skip_next    = 1'b1;
          end
        end
      end
    end
    credit_next = cr;
  end

  // Gate state
  always_ff @(posedge clk) begin
    if (rst) begin
      credit  <= 17'd0;
      blocked <= 1'b1;
      skip    <= 1'b0;
      last    <= 32'd0;
      rec_end <= 33'd0;
      armed   <= 1'b0;
    end else if (cmd.commit) begin
      credit  <= credit_next;
      blocked <= blocked_next;
      skip    <= skip_next;
      last    <= last_next;
      rec_end <= rec_end_next;
      armed   <= armed_next;
    end
  end

  // Output register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pass_event <= pass_next;
      is_blocked <= blocked_next;
    end
  end

endmodule

FILE: rtl/motion_threshold_gate_top.sv
// Top level of the motion threshold gate.
//
// Gates pointer events against a leaky motion credit: the block stays blocked
// until accumulated X/Y motion reaches the threshold, drops the rest of that
// frame, and blocks again once the credit drains. Each event gives one
// result. The inputs are captured at the accepting edge. An event that needs
// decay passes through a multiply step for elapsed time times threshold, the
// bit-serial restoring divider that forms the decay quotient, and an update
// step that writes the output register. Events without decay (no elapsed
// time, zero window, or wake) skip the divider and go from the multiply step
// to the update. A new transaction is accepted the cycle after the update, so
// one event occupies the block until its update, which waits while a stalled
// result holds the output register. The previous result may still be held in
// the output register when the next transaction is accepted. Configuration
// is written on cfg_we; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module motion_threshold_gate_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic               end_of_frame,
  input  logic signed [15:0] event_value,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pass_event,
  output logic               is_blocked
);
  import mtg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .end_of_frame (end_of_frame),
    .event_value  (event_value),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pass_event   (pass_event),
    .is_blocked   (is_blocked),
    .cmd          (cmd),
    .sts          (sts)
  );

  // One transaction in flight: stall goes up right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction still in flight");

  // A result is only written into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending output");

  // A new result appears only after the block was busy with a transaction
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a transaction in flight");

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.mul, cmd.div_step, cmd.commit}))
    else $error("conflicting datapath commands");

endmodule
